/* design/psg_pkg.sv */
// Shared definitions for the PSG tone and noise generator.
// Opcodes, the attenuation table and the channel status struct.
// No dependencies.
`timescale 1ns / 1ps

package psg_pkg;

   localparam int NUM_TONES    = 3;
   localparam int NUM_CHANNELS = 4;
   localparam int CNT_W        = 10;
   localparam int ATT_W        = 4;
   localparam int VOL_W        = 16;
   localparam int LFSR_W       = 16;

   // transaction kinds carried on req_tuser
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_BALANCE = 2'd2;

   localparam logic [ATT_W-1:0]  ATT_SILENT = 4'd15;
   localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'h8000;
   localparam logic [7:0]        MASK_RESET = 8'hff;

   // noise reload values for fixed rates
   localparam logic [CNT_W-1:0] NOISE_RATE0 = 10'h010;
   localparam logic [CNT_W-1:0] NOISE_RATE1 = 10'h020;
   localparam logic [CNT_W-1:0] NOISE_RATE2 = 10'h040;

   // everything the mixer needs for one sample (index 3 is noise)
   typedef struct packed {
      logic                                tick;
      logic [NUM_CHANNELS-1:0]             level;
      logic [NUM_CHANNELS-1:0][ATT_W-1:0]  atten;
      logic [7:0]                          mask;
      logic                                stereo;
   } mix_ctrl_type;

   // 2^(-n/3) in Q0.16, entry 0 saturated, entry 15 silent
   function automatic logic [VOL_W-1:0] vol_lookup(input logic [ATT_W-1:0] att);
      logic [VOL_W-1:0] v;
      case (att)
         4'd0:    v = 16'd65535;
         4'd1:    v = 16'd52016;
         4'd2:    v = 16'd41285;
         4'd3:    v = 16'd32768;
         4'd4:    v = 16'd26008;
         4'd5:    v = 16'd20643;
         4'd6:    v = 16'd16384;
         4'd7:    v = 16'd13004;
         4'd8:    v = 16'd10321;
         4'd9:    v = 16'd8192;
         4'd10:   v = 16'd6502;
         4'd11:   v = 16'd5161;
         4'd12:   v = 16'd4096;
         4'd13:   v = 16'd3251;
         4'd14:   v = 16'd2580;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

/* design/psg_core.sv */
// Channel state of the PSG: tone/noise counters, LFSR, register file.
// Applies one transaction per strobe; depends on psg_pkg.
`timescale 1ns / 1ps

module psg_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  proc_valid,
   input  logic [1:0]            proc_op,
   input  logic [7:0]            proc_data,
   input  logic                  csr_we,
   input  logic                  csr_wdata,
   output psg_pkg::mix_ctrl_type mix_ctrl
);
   import psg_pkg::*;

   logic [NUM_TONES-1:0][CNT_W-1:0] tone_cnt_ff, tone_cnt_in;
   logic [NUM_TONES-1:0][CNT_W-1:0] tone_pitch_ff, tone_pitch_in;
   logic [NUM_TONES-1:0][ATT_W-1:0] tone_att_ff, tone_att_in;
   logic [NUM_TONES-1:0]            tone_lvl_ff, tone_lvl_in;
   logic [CNT_W-1:0]  noise_cnt_ff, noise_cnt_in;
   logic [CNT_W-1:0]  noise_pitch_ff, noise_pitch_in;
   logic [1:0]        noise_rate_ff, noise_rate_in;
   logic              noise_white_ff, noise_white_in;
   logic              noise_flip_ff, noise_flip_in;
   logic              noise_lvl_ff, noise_lvl_in;
   logic [ATT_W-1:0]  noise_att_ff, noise_att_in;
   logic [LFSR_W-1:0] lfsr_ff, lfsr_in;
   logic [2:0]        latch_ff, latch_in;
   logic [7:0]        mask_ff, mask_in;
   logic              stereo_ff, stereo_in;
   logic [1:0]        wr_ch;
   logic              is_tick;

   assign is_tick   = proc_valid && (proc_op == OP_TICK);
   assign stereo_in = csr_we ? csr_wdata : stereo_ff;

   // next state for ticks and register writes
   always_comb begin
      tone_cnt_in    = tone_cnt_ff;
      tone_pitch_in  = tone_pitch_ff;
      tone_att_in    = tone_att_ff;
      tone_lvl_in    = tone_lvl_ff;
      noise_cnt_in   = noise_cnt_ff;
      noise_pitch_in = noise_pitch_ff;
      noise_rate_in  = noise_rate_ff;
      noise_white_in = noise_white_ff;
      noise_flip_in  = noise_flip_ff;
      noise_lvl_in   = noise_lvl_ff;
      noise_att_in   = noise_att_ff;
      lfsr_in        = lfsr_ff;
      latch_in       = latch_ff;
      mask_in        = mask_ff;
      wr_ch          = 2'd0;
      if (proc_valid) begin
         case (proc_op)
            OP_TICK: begin
               // tone channels: reload and toggle at zero
               for (int i = 0; i < NUM_TONES; i++) begin
                  if (tone_cnt_ff[i] == '0) begin
                     tone_cnt_in[i] = tone_pitch_ff[i];
                     tone_lvl_in[i] = ~tone_lvl_ff[i];
                  end else begin
                     tone_cnt_in[i] = tone_cnt_ff[i] - 1'b1;
                  end
               end
               // noise: shift LFSR on every second reload
               if (noise_cnt_ff != '0) begin
                  noise_cnt_in = noise_cnt_ff - 1'b1;
               end else begin
                  case (noise_rate_ff)
                     2'd0:    noise_cnt_in = NOISE_RATE0;
                     2'd1:    noise_cnt_in = NOISE_RATE1;
                     2'd2:    noise_cnt_in = NOISE_RATE2;
                     default: noise_cnt_in = noise_pitch_ff;
                  endcase
                  noise_flip_in = ~noise_flip_ff;
                  if (!noise_flip_ff) begin
                     noise_lvl_in = ~lfsr_ff[0];
                     lfsr_in = {lfsr_ff[0] ^ (lfsr_ff[3] & noise_white_ff),
                                lfsr_ff[LFSR_W-1:1]};
                  end
               end
            end
            OP_WRITE: begin
               if (proc_data[7]) begin
                  latch_in = proc_data[6:4];
               end
               wr_ch = latch_in[2:1];
               if (latch_in[0]) begin
                  // attenuation
                  if (wr_ch == 2'd3) begin
                     noise_att_in = proc_data[3:0];
                  end
                  for (int i = 0; i < NUM_TONES; i++) begin
                     if (wr_ch == 2'(i)) tone_att_in[i] = proc_data[3:0];
                  end
               end else if (proc_data[7]) begin
                  // latch byte: low pitch bits or noise control
                  if (wr_ch == 2'd3) begin
                     noise_rate_in  = proc_data[1:0];
                     noise_white_in = proc_data[2];
                     lfsr_in        = LFSR_SEED;
                  end
                  for (int i = 0; i < NUM_TONES; i++) begin
                     if (wr_ch == 2'(i)) tone_pitch_in[i][3:0] = proc_data[3:0];
                  end
               end else begin
                  // data byte: high pitch bits, noise takes attenuation
                  if (wr_ch == 2'd3) begin
                     noise_att_in = proc_data[3:0];
                  end
                  for (int i = 0; i < NUM_TONES; i++) begin
                     if (wr_ch == 2'(i)) tone_pitch_in[i][9:4] = proc_data[5:0];
                  end
               end
               // tone 2 pitch feeds the noise rate
               if (!latch_in[0] && (wr_ch == 2'd2)) begin
                  noise_pitch_in = tone_pitch_in[2];
               end
            end
            OP_BALANCE: begin
               if (stereo_ff) mask_in = proc_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_cnt_ff    <= '0;
         tone_pitch_ff  <= '0;
         tone_att_ff    <= '0;
         tone_lvl_ff    <= '0;
         noise_cnt_ff   <= '0;
         noise_pitch_ff <= '0;
         noise_rate_ff  <= '0;
         noise_white_ff <= 1'b0;
         noise_flip_ff  <= 1'b0;
         noise_lvl_ff   <= 1'b0;
         noise_att_ff   <= '0;
         lfsr_ff        <= LFSR_SEED;
         latch_ff       <= '0;
         mask_ff        <= MASK_RESET;
         stereo_ff      <= 1'b0;
      end else begin
         tone_cnt_ff    <= tone_cnt_in;
         tone_pitch_ff  <= tone_pitch_in;
         tone_att_ff    <= tone_att_in;
         tone_lvl_ff    <= tone_lvl_in;
         noise_cnt_ff   <= noise_cnt_in;
         noise_pitch_ff <= noise_pitch_in;
         noise_rate_ff  <= noise_rate_in;
         noise_white_ff <= noise_white_in;
         noise_flip_ff  <= noise_flip_in;
         noise_lvl_ff   <= noise_lvl_in;
         noise_att_ff   <= noise_att_in;
         lfsr_ff        <= lfsr_in;
         latch_ff       <= latch_in;
         mask_ff        <= mask_in;
         stereo_ff      <= stereo_in;
      end
   end

   // the sample reflects the levels after this tick
   always_comb begin
      mix_ctrl.tick   = is_tick;
      mix_ctrl.level  = {noise_lvl_in, tone_lvl_in};
      mix_ctrl.atten  = {noise_att_ff, tone_att_ff};
      mix_ctrl.mask   = mask_ff;
      mix_ctrl.stereo = stereo_ff;
   end

endmodule

/* design/psg_mixer.sv */
// Sample mixer and result register of the PSG.
// Looks up channel volumes, sums left/right, holds the result; uses psg_pkg.
`timescale 1ns / 1ps

module psg_mixer (
   input  logic                  clock,
   input  logic                  reset,
   input  psg_pkg::mix_ctrl_type mix_ctrl,
   output logic                  advance,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata
);
   import psg_pkg::*;

   localparam int SUM_W = VOL_W + 2;

   logic [NUM_CHANNELS-1:0][VOL_W-1:0] lv;
   logic [SUM_W-1:0] left_sum, right_sum;
   logic             valid_ff, valid_in;
   logic [VOL_W-1:0] left_ff, left_in, right_ff, right_in;

   assign advance = !valid_ff || rsp_tready;

   // per-channel volume and balance sum
   always_comb begin
      left_sum  = '0;
      right_sum = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         lv[i] = vol_lookup(mix_ctrl.level[i] ? mix_ctrl.atten[i] : ATT_SILENT);
         if (!mix_ctrl.stereo || mix_ctrl.mask[NUM_CHANNELS+i]) begin
            left_sum = left_sum + SUM_W'(lv[i]);
         end
         if (!mix_ctrl.stereo || mix_ctrl.mask[i]) begin
            right_sum = right_sum + SUM_W'(lv[i]);
         end
      end
      left_in  = left_sum[SUM_W-1:2];
      right_in = right_sum[SUM_W-1:2];
   end

   // result register
   assign valid_in = advance ? mix_ctrl.tick : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && mix_ctrl.tick) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {right_ff, left_ff};

endmodule

/* design/psg_tone_noise_generator.sv */
// Top level of the PSG tone and noise generator.
// Input register and handshake; instantiates psg_core and psg_mixer (psg_pkg).
`timescale 1ns / 1ps

// Three square-wave tones and one LFSR noise channel, stepped once per tick
// transaction (req_tuser = 0) and mixed into a left/right Q0.16 sample pair.
// Register write bytes (req_tuser = 1) and balance writes (req_tuser = 2)
// update state and return nothing. Every transaction passes through the
// input register and, for a tick, on into the result register, so one
// transaction is accepted per clock as long as the result side keeps up; a
// stalled result holds the input register and with it req_tready. Write
// csr_wdata (stereo mode) only while no transaction is in flight.
module psg_tone_noise_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] left_sample, [31:16] right_sample
   input  logic        csr_we,
   input  logic        csr_wdata
);
   import psg_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [1:0]   in_op_ff;
   logic [7:0]   in_data_ff;
   logic         advance;
   logic         proc_valid;
   mix_ctrl_type mix_ctrl;

   // input register moves forward when the result side can take a tick
   assign proc_valid  = in_valid_ff && advance;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff   <= req_tuser;
         in_data_ff <= req_tdata;
      end
   end

   psg_core u_core (
      .clock      (clock),
      .reset      (reset),
      .proc_valid (proc_valid),
      .proc_op    (in_op_ff),
      .proc_data  (in_data_ff),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .mix_ctrl   (mix_ctrl)
   );

   psg_mixer u_mixer (
      .clock      (clock),
      .reset      (reset),
      .mix_ctrl   (mix_ctrl),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* verif/psg_checker.sv */
// Scoreboard for the PSG tone and noise generator: follows every transaction,
// predicts each left/right sample pair and compares it with the result stream.
// Depends on psg_pkg for opcodes, widths and reset constants.
`timescale 1ns / 1ps

module psg_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [15:0] left_sample, [31:16] right_sample
   input  logic        csr_we,
   input  logic        csr_wdata,
   output int          fail_count,
   output int          pending
);
   import psg_pkg::*;

   localparam logic [1:0] NOISE_CH = 2'd3;

   // 2^(-n/3) in Q0.16, entry n at bits [16n +: 16]
   localparam logic [16*16-1:0] ATT_LEVEL_TABLE = {
      16'd0,     16'd2580,  16'd3251,  16'd4096,
      16'd5161,  16'd6502,  16'd8192,  16'd10321,
      16'd13004, 16'd16384, 16'd20643, 16'd26008,
      16'd32768, 16'd41285, 16'd52016, 16'd65535
   };

   typedef struct packed {
      logic [VOL_W-1:0] right;
      logic [VOL_W-1:0] left;
   } mix_sample_type;

   mix_sample_type expected_mix_q[$];
   int             n_fail = 0;
   int             n_pending = 0;

   // shadow of the generator state; index 3 of level/atten is noise
   logic                 stereo;
   logic [7:0]           bal_mask;
   logic [CNT_W-1:0]     tone_cnt [NUM_TONES];
   logic [CNT_W-1:0]     tone_pitch [NUM_TONES];
   logic                 level [NUM_CHANNELS];
   logic [ATT_W-1:0]     atten [NUM_CHANNELS];
   logic [CNT_W-1:0]     noise_cnt;
   logic [CNT_W-1:0]     noise_pitch;
   logic [1:0]           noise_rate;
   logic                 noise_white;
   logic                 noise_phase;
   logic [LFSR_W-1:0]    lfsr;
   logic [2:0]           latch_reg;

   assign fail_count = n_fail;
   assign pending    = n_pending;

   task automatic clear_state();
      stereo      = 1'b0;
      bal_mask    = MASK_RESET;
      noise_cnt   = '0;
      noise_pitch = '0;
      noise_rate  = '0;
      noise_white = 1'b0;
      noise_phase = 1'b0;
      lfsr        = LFSR_SEED;
      latch_reg   = '0;
      for (int i = 0; i < NUM_TONES; i++) begin
         tone_cnt[i]   = '0;
         tone_pitch[i] = '0;
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         level[i] = 1'b0;
         atten[i] = '0;
      end
   endtask

   // latch/data register byte
   task automatic apply_reg_byte(input logic [7:0] d);
      logic [1:0] ch;
      if (d[7])
         latch_reg = d[6:4];
      ch = latch_reg[2:1];
      if (latch_reg[0]) begin
         atten[ch] = d[3:0];
      end else if (d[7]) begin
         if (ch == NOISE_CH) begin
            noise_rate  = d[1:0];
            noise_white = d[2];
            lfsr        = LFSR_SEED;
         end else begin
            tone_pitch[ch][3:0] = d[3:0];
            if (ch == 2'd2)
               noise_pitch = tone_pitch[2];
         end
      end else begin
         if (ch == NOISE_CH) begin
            atten[NOISE_CH] = d[3:0];
         end else begin
            tone_pitch[ch][9:4] = d[5:0];
            if (ch == 2'd2)
               noise_pitch = tone_pitch[2];
         end
      end
   endtask

   // one tick: step all counters, then mix
   task automatic tick_channels(output mix_sample_type s);
      logic [VOL_W+1:0] sum_l;
      logic [VOL_W+1:0] sum_r;
      logic [VOL_W-1:0] lvl;
      logic             b0;
      sum_l = '0;
      sum_r = '0;
      for (int i = 0; i < NUM_TONES; i++) begin
         if (tone_cnt[i] == '0) begin
            tone_cnt[i] = tone_pitch[i];
            level[i]    = ~level[i];
         end else begin
            tone_cnt[i] = tone_cnt[i] - 1'b1;
         end
      end
      if (noise_cnt != '0) begin
         noise_cnt = noise_cnt - 1'b1;
      end else begin
         case (noise_rate)
            2'd0:    noise_cnt = NOISE_RATE0;
            2'd1:    noise_cnt = NOISE_RATE1;
            2'd2:    noise_cnt = NOISE_RATE2;
            default: noise_cnt = noise_pitch;
         endcase
         noise_phase = ~noise_phase;
         // shift only on every second reload
         if (noise_phase) begin
            b0              = lfsr[0];
            level[NOISE_CH] = ~b0;
            lfsr            = {b0 ^ (lfsr[3] & noise_white), lfsr[LFSR_W-1:1]};
         end
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         lvl = level[i] ? ATT_LEVEL_TABLE[atten[i]*16 +: 16]
                        : ATT_LEVEL_TABLE[ATT_SILENT*16 +: 16];
         if (!stereo || bal_mask[4+i])
            sum_l = sum_l + lvl;
         if (!stereo || bal_mask[i])
            sum_r = sum_r + lvl;
      end
      s.left  = sum_l[VOL_W+1:2];
      s.right = sum_r[VOL_W+1:2];
   endtask

   // follow csr writes, request and result transactions
   always @(posedge clock) begin
      mix_sample_type want;
      mix_sample_type got;
      if (reset) begin
         clear_state();
         expected_mix_q.delete();
      end else begin
         if (csr_we)
            stereo = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_mix_q.size() == 0) begin
               $error("unexpected result transaction: left %0d right %0d",
                      got.left, got.right);
               n_fail++;
            end else begin
               want = expected_mix_q.pop_front();
               if (got.left !== want.left) begin
                  $error("left_sample: expected %0d, got %0d", want.left, got.left);
                  n_fail++;
               end
               if (got.right !== want.right) begin
                  $error("right_sample: expected %0d, got %0d", want.right, got.right);
                  n_fail++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               OP_TICK: begin
                  tick_channels(want);
                  expected_mix_q.push_back(want);
               end
               OP_WRITE:   apply_reg_byte(req_tdata);
               OP_BALANCE: if (stereo) bal_mask = req_tdata;
               default:    ;
            endcase
         end
      end
      n_pending <= expected_mix_q.size();
   end

endmodule

/* verif/tb_top.sv */
// Testbench top for psg_tone_noise_generator: clock, reset, stimulus with
// bursty sender and stalling receiver, verdict. Uses psg_checker and psg_pkg.
`timescale 1ns / 1ps

module tb_top;
   import psg_pkg::*;

   localparam logic [1:0] OP_UNUSED        = 2'd3;
   localparam int         RANDOM_PER_PHASE = 145;
   localparam int         HOLD_CYCLES      = 300;
   localparam int         CYCLE_LIMIT      = 200000;
   localparam int         NUM_PHASES       = 4;
   localparam logic [NUM_PHASES-1:0] PHASE_STEREO = 4'b1010; // bit p = phase p

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] data
   logic [1:0]  req_tuser = '0;   // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // [15:0] left_sample, [31:16] right_sample
   logic        csr_we = 1'b0;
   logic        csr_wdata = 1'b0;

   int fail_count;
   int pending;
   int burst_left = 1;
   int hold_ticket = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int cycle_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   psg_tone_noise_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   psg_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // receiver: long hold on request, otherwise changing stall patterns
   always @(posedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen  <= hold_ticket;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(16, 80);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // offer one transaction until accepted, then maybe end the burst
   task automatic send_item(input logic [1:0] op, input logic [7:0] d);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         gap        = $urandom_range(0, 5);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop sending and wait until every sample is back and the pipe is empty
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_stereo(input logic v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // mostly ticks and well-formed register bytes, small pitches favored
   task automatic send_random_item();
      int          r;
      logic [1:0]  ch;
      logic [7:0]  d;
      r  = $urandom_range(0, 99);
      ch = 2'($urandom_range(0, 3));
      d  = 8'($urandom_range(0, 255));
      if (r < 55) begin
         send_item(OP_TICK, d);
      end else if (r < 80) begin
         case ($urandom_range(0, 3))
            0: d = {1'b1, ch, 1'b1, d[3:0]};                    // attenuation
            1: d = {1'b1, ch, 1'b0, d[3:0]};                    // pitch low / noise ctrl
            2: d = {1'b0, d[6], ($urandom_range(0, 3) != 0) ? 5'd0 : d[5:1], d[0]};
            default: ;                                          // any byte
         endcase
         send_item(OP_WRITE, d);
      end else if (r < 92) begin
         send_item(OP_BALANCE, d);
      end else begin
         send_item(OP_UNUSED, d);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_stereo(1'b0);

      // directed: extremes, every opcode and register branch
      send_item(OP_UNUSED, 8'hff);
      send_item(OP_BALANCE, 8'h0f);   // ignored in mono
      send_item(OP_TICK, 8'h00);      // all channels at full level
      send_item(OP_TICK, 8'hff);
      send_item(OP_WRITE, 8'h9f);     // tone 0 silent
      send_item(OP_WRITE, 8'hb0);     // tone 1 loudest
      send_item(OP_WRITE, 8'hd7);
      send_item(OP_WRITE, 8'hfe);     // noise attenuation
      send_item(OP_WRITE, 8'h80);
      send_item(OP_WRITE, 8'h3f);     // tone 0 pitch high bits
      send_item(OP_WRITE, 8'haf);
      send_item(OP_WRITE, 8'h00);
      send_item(OP_WRITE, 8'hc3);     // tone 2 pitch, copied to noise
      send_item(OP_WRITE, 8'h40);
      send_item(OP_WRITE, 8'he7);     // noise follows tone 2, white, reseed
      send_item(OP_WRITE, 8'h05);     // data byte on noise: attenuation
      send_item(OP_TICK, 8'h00);
      send_item(OP_TICK, 8'h00);
      send_item(OP_TICK, 8'h00);
      send_item(OP_WRITE, 8'he4);
      send_item(OP_TICK, 8'h00);
      send_item(OP_WRITE, 8'he1);
      send_item(OP_TICK, 8'h00);
      send_item(OP_WRITE, 8'he2);
      send_item(OP_TICK, 8'h00);
      wait_idle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_stereo(PHASE_STEREO[p]);
         if (PHASE_STEREO[p]) begin
            // balance masks with a tick each
            send_item(OP_BALANCE, 8'h00);
            send_item(OP_TICK, 8'h00);
            send_item(OP_BALANCE, 8'hff);
            send_item(OP_TICK, 8'h00);
            send_item(OP_BALANCE, 8'ha5);
            send_item(OP_TICK, 8'h00);
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (p == 1 && n == 70)
               wait_idle();
            if (p == 2 && n == 20)
               hold_ticket <= hold_ticket + 1;
            send_random_item();
         end
         wait_idle();
      end

      if (fail_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
